>>> sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// Isometric tile projection package
// Shared types and constants: the request and response words, the projection
// mode codes and the Q0.24 basis factors.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Projection mode codes held in the mode register.
   typedef enum logic [1:0] {
      MODE_LEGACY   = 2'd0,
      MODE_DIAMOND  = 2'd1,
      MODE_ISO      = 2'd2,
      MODE_DIMETRIC = 2'd3
   } mode_type;

   // Fixed field widths of the request and response words.
   localparam int COORD_W  = 12;
   localparam int LIFT_W   = 4;
   localparam int SCREEN_W = 16;
   localparam int DEPTH_W  = 13;
   localparam int SIZE_W   = 7;

   // Fixed point format of the basis factors.
   localparam int FRAC_BITS = 24;
   localparam int K_W       = 24;

   // Per-unit basis factors, unsigned Q0.24, rounded to nearest.
   localparam int K_HALF       = 8388608;
   localparam int K_QUARTER    = 4194304;
   localparam int K_SQRT3_HALF = 14529495;
   localparam int K_TWO_FIFTHS = 6710886;

   // Screen range limits.
   localparam int SCREEN_MAX = 32767;
   localparam int SCREEN_MIN = -32768;
   localparam int SIZE_MAX   = 127;

   typedef struct packed {
      logic [COORD_W-1:0] tile_x;
      logic [COORD_W-1:0] tile_y;
      logic [LIFT_W-1:0]  tile_z;
   } req_type;

   typedef struct packed {
      logic signed [SCREEN_W-1:0] screen_x;
      logic signed [SCREEN_W-1:0] screen_y;
      logic [DEPTH_W-1:0]         draw_depth;
      logic signed [SCREEN_W-1:0] box_x;
      logic signed [SCREEN_W-1:0] box_y;
      logic [SIZE_W-1:0]          box_w;
      logic [SIZE_W-1:0]          box_h;
   } rsp_type;

   // Load enables of the two stages inside the rounding unit.
   typedef struct packed {
      logic add;
      logic rnd;
   } rnd_en_type;

endpackage

>>> sv/itp_basis.sv
// ----------------------------------------------------------------------------
// Isometric tile projection basis stage
// Selects the screen basis for the mode, forms the two coordinate products in
// Q24 and the corner offsets that turn the anchor into the box extremes.
// ----------------------------------------------------------------------------
module itp_basis #(
   parameter int TILE_SIZE = 8
) (
   input  logic                clock,
   input  logic                en,
   input  itp_pkg::mode_type   mode,
   input  itp_pkg::req_type    tile,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] prod_x,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] prod_y,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x0,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x1,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x2,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_y0,
   output logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_y2,
   output logic [itp_pkg::DEPTH_W-1:0] depth
);

   // Basis width, multiplier operand width and Q24 word width.
   localparam int BW = itp_pkg::K_W + $clog2(TILE_SIZE + 1);
   localparam int MW = itp_pkg::COORD_W + 2;
   localparam int PW = MW + BW + 1;
   localparam int LW = itp_pkg::LIFT_W + $clog2(TILE_SIZE + 1);

   // Q24 basis of one tile step for each mode.
   localparam logic [BW-1:0] B_LEGACY    = BW'(TILE_SIZE) << itp_pkg::FRAC_BITS;
   localparam logic [BW-1:0] B_HALF      = BW'(TILE_SIZE * itp_pkg::K_HALF);
   localparam logic [BW-1:0] B_QUARTER   = BW'(TILE_SIZE * itp_pkg::K_QUARTER);
   localparam logic [BW-1:0] B_SQRT3     = BW'(TILE_SIZE * itp_pkg::K_SQRT3_HALF);
   localparam logic [BW-1:0] B_TWO_FIFTH = BW'(TILE_SIZE * itp_pkg::K_TWO_FIFTHS);

   logic signed [MW-1:0] coord_x, coord_y;
   logic signed [MW-1:0] op_x, op_y;
   logic [BW-1:0]        bas_x, bas_y;
   logic signed [BW:0]   bas_sx, bas_sy;
   logic [LW-1:0]        lift;
   logic signed [PW-1:0] lift_q, leg_q, span_q, bx_q, by2_q;

   logic signed [PW-1:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [PW-1:0] ofs_x0_in, ofs_x1_in, ofs_x2_in, ofs_y0_in, ofs_y2_in;
   logic signed [PW-1:0] ofs_x0_ff, ofs_x1_ff, ofs_x2_ff, ofs_y0_ff, ofs_y2_ff;
   logic [itp_pkg::DEPTH_W-1:0] depth_in, depth_ff;

   // Height lift: z times the tile size, in Q24 as z*T/2 and as the legacy
   // integer lift (z*T)/2 truncated.
   assign coord_x = $signed({{(MW - itp_pkg::COORD_W){1'b0}}, tile.tile_x});
   assign coord_y = $signed({{(MW - itp_pkg::COORD_W){1'b0}}, tile.tile_y});
   assign lift    = LW'(tile.tile_z) * LW'(TILE_SIZE);
   assign lift_q  = $signed(PW'(lift) << (itp_pkg::FRAC_BITS - 1));
   assign leg_q   = $signed(PW'({lift[LW-1:1], 1'b0}) << (itp_pkg::FRAC_BITS - 1));
   assign span_q  = $signed(PW'(B_LEGACY));

   // Basis selection by mode.
   always_comb begin
      bas_x = B_HALF;
      bas_y = B_QUARTER;
      case (mode)
         itp_pkg::MODE_LEGACY: begin
            bas_x = B_LEGACY;
            bas_y = B_LEGACY;
         end
         itp_pkg::MODE_DIAMOND: begin
            bas_x = B_HALF;
            bas_y = B_QUARTER;
         end
         itp_pkg::MODE_ISO: begin
            bas_x = B_SQRT3;
            bas_y = B_HALF;
         end
         itp_pkg::MODE_DIMETRIC: begin
            bas_x = B_SQRT3;
            bas_y = B_TWO_FIFTH;
         end
         default: begin
            bas_x = B_HALF;
            bas_y = B_QUARTER;
         end
      endcase
   end

   assign bas_sx = $signed({1'b0, bas_x});
   assign bas_sy = $signed({1'b0, bas_y});
   assign bx_q   = PW'(bas_sx);
   assign by2_q  = PW'(bas_sy) <<< 1;

   // Multiplier operands and corner offsets. The legacy mode scales x and y
   // directly; the other modes scale the diagonal difference and sum. The
   // least y corner is always the anchor.
   always_comb begin
      if (mode == itp_pkg::MODE_LEGACY) begin
         op_x      = coord_x;
         op_y      = coord_y;
         ofs_x0_in = -leg_q;
         ofs_x1_in = -leg_q;
         ofs_x2_in = span_q - leg_q;
         ofs_y0_in = -leg_q;
         ofs_y2_in = span_q - leg_q;
      end else begin
         op_x      = coord_x - coord_y;
         op_y      = coord_x + coord_y;
         ofs_x0_in = -bx_q;
         ofs_x1_in = '0;
         ofs_x2_in = bx_q;
         ofs_y0_in = -lift_q;
         ofs_y2_in = by2_q - lift_q;
      end
   end

   assign prod_x_in = PW'(op_x) * PW'(bas_sx);
   assign prod_y_in = PW'(op_y) * PW'(bas_sy);
   assign depth_in  = itp_pkg::DEPTH_W'(tile.tile_x) + itp_pkg::DEPTH_W'(tile.tile_y);

   // Stage register.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         ofs_x0_ff <= ofs_x0_in;
         ofs_x1_ff <= ofs_x1_in;
         ofs_x2_ff <= ofs_x2_in;
         ofs_y0_ff <= ofs_y0_in;
         ofs_y2_ff <= ofs_y2_in;
         depth_ff  <= depth_in;
      end
   end

   assign prod_x = prod_x_ff;
   assign prod_y = prod_y_ff;
   assign ofs_x0 = ofs_x0_ff;
   assign ofs_x1 = ofs_x1_ff;
   assign ofs_x2 = ofs_x2_ff;
   assign ofs_y0 = ofs_y0_ff;
   assign ofs_y2 = ofs_y2_ff;
   assign depth  = depth_ff;

endmodule

>>> sv/itp_round.sv
// ----------------------------------------------------------------------------
// Isometric tile projection rounding unit
// Adds the corner offsets to the products, then rounds each Q24 corner value
// to an integer, half away from zero. Two register stages.
// ----------------------------------------------------------------------------
module itp_round #(
   parameter int TILE_SIZE = 8
) (
   input  logic                clock,
   input  itp_pkg::rnd_en_type en,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] prod_x,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] prod_y,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x0,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x1,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_x2,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_y0,
   input  logic signed [itp_pkg::K_W + $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ofs_y2,
   input  logic [itp_pkg::DEPTH_W-1:0] depth_a,
   output logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx0,
   output logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx1,
   output logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx2,
   output logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ry0,
   output logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ry2,
   output logic [itp_pkg::DEPTH_W-1:0] depth_r
);

   localparam int BW = itp_pkg::K_W + $clog2(TILE_SIZE + 1);
   localparam int PW = BW + itp_pkg::COORD_W + 3;
   localparam int RW = PW - itp_pkg::FRAC_BITS;

   // Rounding bias: one half for positive values, just under one half for
   // negative ones, so that an arithmetic shift rounds half away from zero.
   localparam logic signed [PW-1:0] Q_HALF    = PW'(1) << (itp_pkg::FRAC_BITS - 1);
   localparam logic signed [PW-1:0] Q_HALF_M1 = Q_HALF - PW'(1);

   logic signed [PW-1:0] sum_x0_in, sum_x1_in, sum_x2_in, sum_y0_in, sum_y2_in;
   logic signed [PW-1:0] sum_x0_ff, sum_x1_ff, sum_x2_ff, sum_y0_ff, sum_y2_ff;
   logic [itp_pkg::DEPTH_W-1:0] depth_s_ff, depth_r_ff;
   logic signed [RW-1:0] rx0_in, rx1_in, rx2_in, ry0_in, ry2_in;
   logic signed [RW-1:0] rx0_ff, rx1_ff, rx2_ff, ry0_ff, ry2_ff;

   function automatic logic signed [RW-1:0] round_q(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v + (v[PW-1] ? Q_HALF_M1 : Q_HALF);
      return t[PW-1:itp_pkg::FRAC_BITS];
   endfunction

   // Corner values in Q24.
   assign sum_x0_in = prod_x + ofs_x0;
   assign sum_x1_in = prod_x + ofs_x1;
   assign sum_x2_in = prod_x + ofs_x2;
   assign sum_y0_in = prod_y + ofs_y0;
   assign sum_y2_in = prod_y + ofs_y2;

   always_ff @(posedge clock) begin
      if (en.add) begin
         sum_x0_ff  <= sum_x0_in;
         sum_x1_ff  <= sum_x1_in;
         sum_x2_ff  <= sum_x2_in;
         sum_y0_ff  <= sum_y0_in;
         sum_y2_ff  <= sum_y2_in;
         depth_s_ff <= depth_a;
      end
   end

   // Rounding to integer screen positions.
   assign rx0_in = round_q(sum_x0_ff);
   assign rx1_in = round_q(sum_x1_ff);
   assign rx2_in = round_q(sum_x2_ff);
   assign ry0_in = round_q(sum_y0_ff);
   assign ry2_in = round_q(sum_y2_ff);

   always_ff @(posedge clock) begin
      if (en.rnd) begin
         rx0_ff     <= rx0_in;
         rx1_ff     <= rx1_in;
         rx2_ff     <= rx2_in;
         ry0_ff     <= ry0_in;
         ry2_ff     <= ry2_in;
         depth_r_ff <= depth_s_ff;
      end
   end

   assign rx0     = rx0_ff;
   assign rx1     = rx1_ff;
   assign rx2     = rx2_ff;
   assign ry0     = ry0_ff;
   assign ry2     = ry2_ff;
   assign depth_r = depth_r_ff;

endmodule

>>> sv/itp_box.sv
// ----------------------------------------------------------------------------
// Isometric tile projection box stage
// Saturates the anchor and box corner to the screen range, forms the box
// width and height clamped to between one and 127, and holds the response word.
// ----------------------------------------------------------------------------
module itp_box #(
   parameter int TILE_SIZE = 8
) (
   input  logic                clock,
   input  logic                en,
   input  logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx0,
   input  logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx1,
   input  logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] rx2,
   input  logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ry0,
   input  logic signed [$clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 2:0] ry2,
   input  logic [itp_pkg::DEPTH_W-1:0] depth,
   output itp_pkg::rsp_type    rsp_word
);

   localparam int RW = $clog2(TILE_SIZE + 1) + itp_pkg::COORD_W + 3;

   localparam logic signed [RW-1:0] S_MAX = RW'(itp_pkg::SCREEN_MAX);
   localparam logic signed [RW-1:0] S_MIN = RW'(itp_pkg::SCREEN_MIN);
   localparam logic signed [RW:0]   W_ONE = (RW + 1)'(1);
   localparam logic signed [RW:0]   W_MAX = (RW + 1)'(itp_pkg::SIZE_MAX);

   logic signed [RW:0] span_x, span_y;
   itp_pkg::rsp_type   rsp_in, rsp_ff;

   function automatic logic signed [itp_pkg::SCREEN_W-1:0] sat16(
      input logic signed [RW-1:0] v);
      logic signed [RW-1:0] t;
      t = v;
      if (v > S_MAX) t = S_MAX;
      if (v < S_MIN) t = S_MIN;
      return t[itp_pkg::SCREEN_W-1:0];
   endfunction

   function automatic logic [itp_pkg::SIZE_W-1:0] clamp_size(input logic signed [RW:0] v);
      logic signed [RW:0] t;
      t = v;
      if (v < W_ONE) t = W_ONE;
      if (v > W_MAX) t = W_MAX;
      return t[itp_pkg::SIZE_W-1:0];
   endfunction

   // Box extent from the unsaturated corners.
   assign span_x = $signed({rx2[RW-1], rx2}) - $signed({rx0[RW-1], rx0});
   assign span_y = $signed({ry2[RW-1], ry2}) - $signed({ry0[RW-1], ry0});

   always_comb begin
      rsp_in.screen_x   = sat16(rx1);
      rsp_in.screen_y   = sat16(ry0);
      rsp_in.draw_depth = depth;
      rsp_in.box_x      = sat16(rx0);
      rsp_in.box_y      = sat16(ry0);
      rsp_in.box_w      = clamp_size(span_x);
      rsp_in.box_h      = clamp_size(span_y);
   end

   // Response register; it holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> sv/iso_tile_projection_top.sv
// ----------------------------------------------------------------------------
// Isometric tile projection
// Maps a tile coordinate and height to a screen anchor, a draw depth and a
// screen bounding box under one of four projection modes.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) takes one tile word
//   per cycle while req_stall is low. The response channel (rsp_valid,
//   rsp_stall, rsp_data) returns one result word per tile, in order. A word
//   moves at a clock edge where its valid is high and its stall is low.
//   The csr_ port writes the 2-bit projection mode; write it only while no
//   tile is in flight. Each tile uses the mode that was set when it entered.
//   Path: an accepted tile passes in order through the input register,
//   product stage, offset add, rounding and response register.
//   Throughput: one tile per cycle while rsp_stall is low, set by the single
//   pass through the five registered stages with one multiplier per axis.
//   Stall: when rsp_stall is high the response word holds; the stages behind
//   it keep filling any empty slots, and req_stall rises only once every
//   stage holds a tile.
//   Reset: synchronous, active high; empties the pipeline and sets the mode
//   to legacy square.
// ----------------------------------------------------------------------------
module iso_tile_projection_top #(
   parameter int TILE_SIZE = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  itp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output itp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   localparam int BW = itp_pkg::K_W + $clog2(TILE_SIZE + 1);
   localparam int PW = BW + itp_pkg::COORD_W + 3;
   localparam int RW = PW - itp_pkg::FRAC_BITS;

   itp_pkg::mode_type   mode_in, mode_ff, mode_s1_ff;
   itp_pkg::req_type    tile_ff;
   logic                v1_in, v2_in, v3_in, v4_in, rsp_valid_in;
   logic                v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic                rdy1, rdy2, rdy3, rdy4, rdy5;
   itp_pkg::rnd_en_type rnd_en;

   logic signed [PW-1:0] prod_x, prod_y, ofs_x0, ofs_x1, ofs_x2, ofs_y0, ofs_y2;
   logic signed [RW-1:0] rx0, rx1, rx2, ry0, ry2;
   logic [itp_pkg::DEPTH_W-1:0] depth_a, depth_r;

   // Stage readiness: a stage loads when it is empty or its word moves on.
   assign rdy5      = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !v4_ff || rdy5;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   assign v1_in        = rdy1 ? req_valid : v1_ff;
   assign v2_in        = rdy2 ? v1_ff : v2_ff;
   assign v3_in        = rdy3 ? v2_ff : v3_ff;
   assign v4_in        = rdy4 ? v3_ff : v4_ff;
   assign rsp_valid_in = rdy5 ? v4_ff : rsp_valid_ff;
   assign mode_in      = csr_wr_en ? itp_pkg::mode_type'(csr_wr_data) : mode_ff;

   // Control state: mode register and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= itp_pkg::MODE_LEGACY;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (rdy1) begin
         tile_ff    <= req_data;
         mode_s1_ff <= mode_ff;
      end
   end

   itp_basis #(
      .TILE_SIZE (TILE_SIZE)
   ) u_basis (
      .clock  (clock),
      .en     (rdy2),
      .mode   (mode_s1_ff),
      .tile   (tile_ff),
      .prod_x (prod_x),
      .prod_y (prod_y),
      .ofs_x0 (ofs_x0),
      .ofs_x1 (ofs_x1),
      .ofs_x2 (ofs_x2),
      .ofs_y0 (ofs_y0),
      .ofs_y2 (ofs_y2),
      .depth  (depth_a)
   );

   assign rnd_en.add = rdy3;
   assign rnd_en.rnd = rdy4;

   itp_round #(
      .TILE_SIZE (TILE_SIZE)
   ) u_round (
      .clock   (clock),
      .en      (rnd_en),
      .prod_x  (prod_x),
      .prod_y  (prod_y),
      .ofs_x0  (ofs_x0),
      .ofs_x1  (ofs_x1),
      .ofs_x2  (ofs_x2),
      .ofs_y0  (ofs_y0),
      .ofs_y2  (ofs_y2),
      .depth_a (depth_a),
      .rx0     (rx0),
      .rx1     (rx1),
      .rx2     (rx2),
      .ry0     (ry0),
      .ry2     (ry2),
      .depth_r (depth_r)
   );

   itp_box #(
      .TILE_SIZE (TILE_SIZE)
   ) u_box (
      .clock    (clock),
      .en       (rdy5),
      .rx0      (rx0),
      .rx1      (rx1),
      .rx2      (rx2),
      .ry0      (ry0),
      .ry2      (ry2),
      .depth    (depth_r),
      .rsp_word (rsp_data)
   );

   assign rsp_valid = rsp_valid_ff;

   // Reset empties the response stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !v1_ff)
      else $error("pipeline not empty after reset");

   // Requests are held off only when every stage is full and the output stalls.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled with a free stage");

   // A word in the input stage moves on when the next stage can take it.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      v1_ff && rdy2 |=> v2_ff)
      else $error("word lost between input and product stage");

   // Rounding keeps the corner order, so the box never turns inside out.
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (rx2 >= rx0) && (ry2 >= ry0) && (rx1 >= rx0) && (rx2 >= rx1))
      else $error("rounded corners out of order");

   // Box sizes are never zero on a valid response.
   a_box_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data.box_w != '0) && (rsp_data.box_h != '0))
      else $error("zero box size");

endmodule
